/* hdl/etcl_pkg.sv */
// ----------------------------------------------------------------------------
// etcl_pkg
// Shared constants, codes and types for the empty/taken cell list block.
// ----------------------------------------------------------------------------
package etcl_pkg;

  localparam int CELLS   = 128;
  localparam int CIDX_W  = $clog2(CELLS);
  localparam int LINK_W  = 8;
  localparam int CNT_W   = 8;
  localparam int PIECE_W = 2;

  localparam int LINK_RAM_W = 2 * LINK_W;
  localparam int CELL_RAM_W = PIECE_W + 2;

  localparam logic [LINK_W-1:0]  NONE_LINK   = LINK_W'(CELLS);
  localparam logic [PIECE_W-1:0] EMPTY_PIECE = PIECE_W'(2);

  typedef logic [LINK_W-1:0]  link_t;
  typedef logic [CIDX_W-1:0]  idx_t;
  typedef logic [PIECE_W-1:0] piece_t;
  typedef logic [CNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    FN_ADD      = 2'd0,
    FN_REMOVE   = 2'd1,
    FN_SET_NEXT = 2'd2,
    FN_READ     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CELL,
    ST_PREV,
    ST_NEXT,
    ST_TAIL,
    ST_COMMIT,
    ST_RESULT
  } state_t;

  // Access to the cell store: one read address, one link write, one cell write.
  typedef struct packed {
    logic   rd;
    idx_t   rd_addr;
    logic   link_wr;
    idx_t   link_addr;
    link_t  wr_prev;
    link_t  wr_next;
    logic   cell_wr;
    idx_t   cell_addr;
    piece_t wr_piece;
    logic   wr_player;
    logic   wr_taken;
  } store_req_t;

  typedef struct packed {
    link_t  prev;
    link_t  next;
    piece_t piece;
    logic   player;
    logic   taken;
  } entry_t;

  typedef struct packed {
    logic   error;
    link_t  cell_prev;
    link_t  cell_next;
    piece_t cell_piece;
    logic   cell_player;
    link_t  first_empty;
    link_t  last_empty;
    link_t  first_taken;
    link_t  last_taken;
    count_t empty_count;
    count_t taken_count;
    piece_t next_piece;
  } result_t;

  function automatic logic link_ok(input link_t l);
    return l < NONE_LINK;
  endfunction

endpackage

/* hdl/etcl_ram.sv */
// ----------------------------------------------------------------------------
// etcl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module etcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/etcl_store.sv */
// ----------------------------------------------------------------------------
// etcl_store
// Cell store: link RAM and cell RAM, with per-entry written flags so that an
// entry never written reads as its reset value.
// ----------------------------------------------------------------------------
module etcl_store import etcl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  store_req_t req,
  output entry_t     rdata
);

  logic [CELLS-1:0]      link_vld;
  logic [CELLS-1:0]      cell_vld;
  idx_t                  rd_addr_q;
  logic                  link_vld_q;
  logic                  cell_vld_q;
  logic [LINK_RAM_W-1:0] link_rd;
  logic [CELL_RAM_W-1:0] cell_rd;
  link_t                 dflt_prev;
  link_t                 dflt_next;

  etcl_ram #(
    .WIDTH(LINK_RAM_W),
    .DEPTH(CELLS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (req.link_wr),
    .wr_addr (req.link_addr),
    .wr_data ({req.wr_prev, req.wr_next}),
    .rd_en   (req.rd),
    .rd_addr (req.rd_addr),
    .rd_data (link_rd)
  );

  etcl_ram #(
    .WIDTH(CELL_RAM_W),
    .DEPTH(CELLS)
  ) u_cell_ram (
    .clk     (clk),
    .wr_en   (req.cell_wr),
    .wr_addr (req.cell_addr),
    .wr_data ({req.wr_piece, req.wr_player, req.wr_taken}),
    .rd_en   (req.rd),
    .rd_addr (req.rd_addr),
    .rd_data (cell_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      link_vld <= '0;
      cell_vld <= '0;
    end else begin
      if (req.link_wr) begin
        link_vld[req.link_addr] <= 1'b1;
      end
      if (req.cell_wr) begin
        cell_vld[req.cell_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd) begin
      rd_addr_q  <= req.rd_addr;
      link_vld_q <= link_vld[req.rd_addr];
      cell_vld_q <= cell_vld[req.rd_addr];
    end
  end

  // Reset pattern: ascending order, ends of the list point at none
  assign dflt_prev = (rd_addr_q == '0) ? NONE_LINK
                                       : LINK_W'(rd_addr_q) - LINK_W'(1);
  assign dflt_next = (rd_addr_q == idx_t'(CELLS - 1)) ? NONE_LINK
                                                      : LINK_W'(rd_addr_q) + LINK_W'(1);

  always_comb begin
    if (link_vld_q) begin
      rdata.prev = link_rd[LINK_RAM_W-1:LINK_W];
      rdata.next = link_rd[LINK_W-1:0];
    end else begin
      rdata.prev = dflt_prev;
      rdata.next = dflt_next;
    end
    if (cell_vld_q) begin
      rdata.piece  = cell_rd[CELL_RAM_W-1:2];
      rdata.player = cell_rd[1];
      rdata.taken  = cell_rd[0];
    end else begin
      rdata.piece  = EMPTY_PIECE;
      rdata.player = 1'b0;
      rdata.taken  = 1'b0;
    end
  end

endmodule

/* hdl/etcl_seq.sv */
// ----------------------------------------------------------------------------
// etcl_seq
// Sequencer: walks one word through the link updates in the cell store and
// keeps the list heads, tails, counts and the pending piece.
// ----------------------------------------------------------------------------
module etcl_seq import etcl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  func_t      func_in,
  input  idx_t       pos_in,
  input  logic       player_in,
  input  piece_t     piece_in,
  output logic       idle,
  input  logic       out_free,
  output logic       res_load,
  output result_t    res,
  output store_req_t req,
  input  entry_t     rdata
);

  state_t state;
  state_t state_next;

  func_t  func_q;
  idx_t   pos_q;
  logic   player_q;
  piece_t piece_q;
  logic   err_q;
  link_t  pv_q;
  link_t  nx_q;
  link_t  dt_q;
  link_t  c_prev;
  link_t  c_next;
  piece_t c_piece;
  logic   c_player;

  link_t  empty_head;
  link_t  empty_tail;
  link_t  taken_head;
  link_t  taken_tail;
  count_t empty_total;
  count_t taken_total;
  piece_t pending_piece;

  logic   is_add;
  logic   is_move;
  logic   pos_ok;
  logic   err;
  link_t  p_link;

  assign is_add  = (func_q == FN_ADD);
  assign is_move = (func_q == FN_ADD) || (func_q == FN_REMOVE);
  assign p_link  = LINK_W'(pos_q);
  assign pos_ok  = p_link < NONE_LINK;
  assign err     = (is_add && (!pos_ok || rdata.taken)) ||
                   ((func_q == FN_REMOVE) && (!pos_ok || !rdata.taken));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_CELL;
      end
      ST_CELL: begin
        state_next = (is_move && !err) ? ST_PREV : ST_RESULT;
      end
      ST_PREV:   state_next = ST_NEXT;
      ST_NEXT:   state_next = ST_TAIL;
      ST_TAIL:   state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_RESULT;
      ST_RESULT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Store accesses and handshake
  always_comb begin
    req      = '0;
    idle     = 1'b0;
    res_load = 1'b0;
    case (state)
      ST_IDLE: begin
        idle        = 1'b1;
        req.rd      = in_fire;
        req.rd_addr = pos_in;
      end
      ST_CELL: begin
        req.rd      = is_move && !err && link_ok(rdata.prev);
        req.rd_addr = rdata.prev[CIDX_W-1:0];
      end
      ST_PREV: begin
        // predecessor skips over the moved cell
        req.link_wr   = link_ok(pv_q);
        req.link_addr = pv_q[CIDX_W-1:0];
        req.wr_prev   = rdata.prev;
        req.wr_next   = nx_q;
        req.rd        = link_ok(nx_q);
        req.rd_addr   = nx_q[CIDX_W-1:0];
      end
      ST_NEXT: begin
        req.link_wr   = link_ok(nx_q);
        req.link_addr = nx_q[CIDX_W-1:0];
        req.wr_prev   = pv_q;
        req.wr_next   = rdata.next;
        req.rd        = link_ok(dt_q);
        req.rd_addr   = dt_q[CIDX_W-1:0];
      end
      ST_TAIL: begin
        // old tail of the destination list now points at the moved cell
        req.link_wr   = link_ok(dt_q);
        req.link_addr = dt_q[CIDX_W-1:0];
        req.wr_prev   = rdata.prev;
        req.wr_next   = p_link;
      end
      ST_COMMIT: begin
        req.link_wr   = 1'b1;
        req.link_addr = pos_q;
        req.wr_prev   = link_ok(dt_q) ? dt_q : NONE_LINK;
        req.wr_next   = NONE_LINK;
        req.cell_wr   = 1'b1;
        req.cell_addr = pos_q;
        req.wr_piece  = is_add ? piece_q : EMPTY_PIECE;
        req.wr_player = is_add ? player_q : c_player;
        req.wr_taken  = is_add;
      end
      ST_RESULT: begin
        res_load = out_free;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      empty_head    <= '0;
      empty_tail    <= LINK_W'(CELLS - 1);
      taken_head    <= NONE_LINK;
      taken_tail    <= NONE_LINK;
      empty_total   <= CNT_W'(CELLS);
      taken_total   <= '0;
      pending_piece <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CELL && func_q == FN_SET_NEXT) begin
        pending_piece <= piece_q;
      end
      if (state == ST_COMMIT) begin
        if (is_add) begin
          if (!link_ok(pv_q)) empty_head <= nx_q;
          if (!link_ok(nx_q)) empty_tail <= pv_q;
          if (!link_ok(dt_q)) taken_head <= p_link;
          taken_tail  <= p_link;
          empty_total <= empty_total - CNT_W'(1);
          taken_total <= taken_total + CNT_W'(1);
        end else begin
          if (!link_ok(pv_q)) taken_head <= nx_q;
          if (!link_ok(nx_q)) taken_tail <= pv_q;
          if (!link_ok(dt_q)) empty_head <= p_link;
          empty_tail  <= p_link;
          empty_total <= empty_total + CNT_W'(1);
          taken_total <= taken_total - CNT_W'(1);
        end
      end
    end
  end

  // Word registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      func_q   <= func_in;
      pos_q    <= pos_in;
      player_q <= player_in;
      piece_q  <= piece_in;
    end
    if (state == ST_CELL) begin
      err_q <= err;
      pv_q  <= rdata.prev;
      nx_q  <= rdata.next;
      dt_q  <= is_add ? taken_tail : empty_tail;
      if (pos_ok) begin
        c_prev   <= rdata.prev;
        c_next   <= rdata.next;
        c_piece  <= rdata.piece;
        c_player <= rdata.player;
      end else begin
        c_prev   <= NONE_LINK;
        c_next   <= NONE_LINK;
        c_piece  <= EMPTY_PIECE;
        c_player <= 1'b0;
      end
    end
    if (state == ST_COMMIT) begin
      c_prev   <= link_ok(dt_q) ? dt_q : NONE_LINK;
      c_next   <= NONE_LINK;
      c_piece  <= is_add ? piece_q : EMPTY_PIECE;
      c_player <= is_add ? player_q : c_player;
    end
  end

  always_comb begin
    res.error       = err_q;
    res.cell_prev   = c_prev;
    res.cell_next   = c_next;
    res.cell_piece  = c_piece;
    res.cell_player = c_player;
    res.first_empty = empty_head;
    res.last_empty  = empty_tail;
    res.first_taken = taken_head;
    res.last_taken  = taken_tail;
    res.empty_count = empty_total;
    res.taken_count = taken_total;
    res.next_piece  = pending_piece;
  end

endmodule

/* hdl/empty_taken_cell_lists.sv */
// ----------------------------------------------------------------------------
// empty_taken_cell_lists
// Board cells kept on two index-linked lists, empty and taken.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one word: func, pos, player, piece.
// Add moves a cell from the empty list to the taken tail, remove moves it
// back to the empty tail, set-next stores the pending piece, read changes
// nothing. Each word gives exactly one result word on the output channel
// (out_valid/out_ready): the cell's links and contents after the operation,
// all heads, tails and counts, the pending piece and an error flag for a
// refused add or remove.
// Sequence: a read, set-next or refused operation passes through the cell
// read and result states; a move also passes through the predecessor,
// successor, tail and commit states, one link read-modify-write per cycle
// through the single write port of the link memory. The next word is taken
// once the result is in the output register. Only one word is in flight at a time.
// The result sits in an output register; while the receiver stalls the block
// still accepts the next word and holds its result until the register frees.
// Reset (rst, synchronous) restores ascending cell order on the empty list at
// once through per-entry written flags; no clearing pass is needed.
// ----------------------------------------------------------------------------
module empty_taken_cell_lists import etcl_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [1:0]   func,
  input  logic [6:0]   pos,
  input  logic         player,
  input  logic [1:0]   piece,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         error,
  output logic [7:0]   cell_prev,
  output logic [7:0]   cell_next,
  output logic [1:0]   cell_piece_out,
  output logic         cell_player_out,
  output logic [7:0]   first_empty,
  output logic [7:0]   last_empty,
  output logic [7:0]   first_taken,
  output logic [7:0]   last_taken,
  output logic [7:0]   empty_count,
  output logic [7:0]   taken_count,
  output logic [1:0]   next_piece
);

  logic       idle;
  logic       in_fire;
  logic       out_free;
  logic       res_load;
  result_t    res;
  result_t    res_q;
  store_req_t req;
  entry_t     rdata;

  assign in_ready = idle;
  assign in_fire  = in_valid && idle;
  assign out_free = !out_valid || out_ready;

  etcl_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .func_in   (func_t'(func)),
    .pos_in    (idx_t'(pos)),
    .player_in (player),
    .piece_in  (piece_t'(piece)),
    .idle      (idle),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .req       (req),
    .rdata     (rdata)
  );

  etcl_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_q <= res;
    end
  end

  assign error           = res_q.error;
  assign cell_prev       = res_q.cell_prev;
  assign cell_next       = res_q.cell_next;
  assign cell_piece_out  = res_q.cell_piece;
  assign cell_player_out = res_q.cell_player;
  assign first_empty     = res_q.first_empty;
  assign last_empty      = res_q.last_empty;
  assign first_taken     = res_q.first_taken;
  assign last_taken      = res_q.last_taken;
  assign empty_count     = res_q.empty_count;
  assign taken_count     = res_q.taken_count;
  assign next_piece      = res_q.next_piece;

endmodule

/* hdl/etcl_checker.sv */
// ----------------------------------------------------------------------------
// etcl_checker
// Port-level checks for the empty/taken cell lists, bound to the top level.
// ----------------------------------------------------------------------------
module etcl_checker import etcl_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] func,
  input logic [6:0] pos,
  input logic       player,
  input logic [1:0] piece,
  input logic       out_valid,
  input logic       out_ready,
  input logic       error,
  input logic [7:0] cell_prev,
  input logic [7:0] cell_next,
  input logic [1:0] cell_piece_out,
  input logic       cell_player_out,
  input logic [7:0] first_empty,
  input logic [7:0] last_empty,
  input logic [7:0] first_taken,
  input logic [7:0] last_taken,
  input logic [7:0] empty_count,
  input logic [7:0] taken_count,
  input logic [1:0] next_piece
);

  // One word in flight: ready drops after each acceptance
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in flight");

  // Hold the input word until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(func) && $stable(pos) &&
      $stable(player) && $stable(piece))
    else $error("input word changed while waiting");

  // Every cell sits on exactly one list
  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (9'(empty_count) + 9'(taken_count)) == 9'(CELLS))
    else $error("list counts do not add up to the cell total");

  // An empty list has no head and no tail
  a_empty_lists: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      ((empty_count != '0) || (first_empty == NONE_LINK && last_empty == NONE_LINK)) &&
      ((taken_count != '0) || (first_taken == NONE_LINK && last_taken == NONE_LINK)))
    else $error("empty list reports a head or tail");

  // Hold the result word while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(error) && $stable(cell_prev) &&
      $stable(cell_next) && $stable(cell_piece_out) && $stable(cell_player_out) &&
      $stable(first_empty) && $stable(last_empty) && $stable(first_taken) &&
      $stable(last_taken) && $stable(empty_count) && $stable(taken_count) &&
      $stable(next_piece))
    else $error("result word changed while stalled");

endmodule

bind empty_taken_cell_lists etcl_checker u_etcl_checker (.*);
